/* rtl/fvl_pkg.sv */
// ----------------------------------------------------------------------------
// fvl_pkg
// Shared types and constants of the firmware image check and load block.
// ----------------------------------------------------------------------------
package fvl_pkg;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [6:0]  CRC_LEN  = 7'd9;

    localparam logic [7:0]  ABI_RESET   = 8'h01;
    localparam logic [15:0] LIMIT_RESET = 16'hD000;
    localparam logic [15:0] BASE_RESET  = 16'h3000;

    // configuration register indexes
    localparam logic [1:0] CFG_ABI   = 2'd0;
    localparam logic [1:0] CFG_LIMIT = 2'd1;
    localparam logic [1:0] CFG_BASE  = 2'd2;

    // verdict codes
    localparam logic [2:0] V_OK     = 3'd0;
    localparam logic [2:0] V_MAGIC  = 3'd1;
    localparam logic [2:0] V_ABI    = 3'd2;
    localparam logic [2:0] V_LENGTH = 3'd3;
    localparam logic [2:0] V_CRC    = 3'd4;

    // header magic, bytes 0..3
    localparam logic [7:0] MAGIC [4] = '{8'h41, 8'h32, 8'h34, 8'h46};

    // reflected CRC-32 nibble table, polynomial 0xEDB88320
    localparam logic [31:0] NIB_TAB [16] = '{
        32'h0000_0000, 32'h1DB7_1064, 32'h3B6E_20C8, 32'h26D9_30AC,
        32'h76DC_4190, 32'h6B6B_51F4, 32'h4DB2_6158, 32'h5005_713C,
        32'hEDB8_8320, 32'hF00F_9344, 32'hD6D6_A3E8, 32'hCB61_B38C,
        32'h9B64_C2B0, 32'h86D3_D2D4, 32'hA00A_E278, 32'hBDBD_F21C
    };

    typedef struct packed {
        logic        store_valid;
        logic [15:0] store_addr;
        logic [7:0]  store_data;
        logic        done_res;
        logic [2:0]  verdict;
    } t_result;

    typedef struct packed {
        logic [7:0]  expected_abi;
        logic [15:0] body_limit;
        logic [15:0] load_base;
    } t_cfg;

endpackage

/* rtl/fvl_crc_byte.sv */
// ----------------------------------------------------------------------------
// fvl_crc_byte
// One byte step of the reflected CRC-32, two nibble table lookups.
// ----------------------------------------------------------------------------
module fvl_crc_byte
    import fvl_pkg::*;
(
    input  logic [31:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_crc
);

    logic [31:0] x0;
    logic [31:0] x1;

    always_comb begin
        x0    = i_crc ^ {24'd0, i_byte};
        x1    = (x0 >> 4) ^ NIB_TAB[x0[3:0]];
        o_crc = (x1 >> 4) ^ NIB_TAB[x1[3:0]];
    end

endmodule

/* rtl/fvl_parse.sv */
// ----------------------------------------------------------------------------
// fvl_parse
// Header parser and body sequencer: holds the image state and works out the
// result of each accepted byte.
// ----------------------------------------------------------------------------
module fvl_parse
    import fvl_pkg::*;
#(
    parameter int HEADER_LENGTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [7:0]  i_byte,
    input  t_cfg        i_cfg,
    output t_result     o_result
);

    localparam logic [6:0] HDR_LAST = 7'(HEADER_LENGTH - 1);

    logic [6:0]  r_hdr_idx,   n_hdr_idx;
    logic        r_in_body,   n_in_body;
    logic [15:0] r_body_idx,  n_body_idx;
    logic [31:0] r_crc,       n_crc;
    logic [15:0] r_len,       n_len;
    logic        r_len_hi,    n_len_hi;
    logic [31:0] r_dcrc,      n_dcrc;
    logic        r_magic_bad, n_magic_bad;
    logic        r_abi_bad,   n_abi_bad;

    logic [31:0] crc_step;
    logic [1:0]  len_sel;
    logic [1:0]  dcrc_sel;
    logic [15:0] body_next;
    logic        rearm;

    fvl_crc_byte u_crc (
        .i_crc  (r_crc),
        .i_byte (i_byte),
        .o_crc  (crc_step)
    );

    always_comb begin
        n_hdr_idx   = r_hdr_idx;
        n_in_body   = r_in_body;
        n_body_idx  = r_body_idx;
        n_crc       = r_crc;
        n_len       = r_len;
        n_len_hi    = r_len_hi;
        n_dcrc      = r_dcrc;
        n_magic_bad = r_magic_bad;
        n_abi_bad   = r_abi_bad;
        rearm       = 1'b0;
        o_result    = '0;
        len_sel     = 2'(r_hdr_idx - 7'd5);
        dcrc_sel    = 2'(r_hdr_idx - 7'd9);
        body_next   = r_body_idx + 16'd1;

        if (r_in_body) begin
            o_result.store_valid = 1'b1;
            o_result.store_addr  = i_cfg.load_base + r_body_idx;
            o_result.store_data  = i_byte;
            n_crc                = crc_step;
            n_body_idx           = body_next;
            if (body_next == r_len) begin
                o_result.done_res = 1'b1;
                o_result.verdict  = ((~crc_step) == r_dcrc) ? V_OK : V_CRC;
                rearm             = 1'b1;
            end
        end else begin
            case (r_hdr_idx) inside
                [7'd0:7'd3]: begin
                    if (i_byte != MAGIC[r_hdr_idx[1:0]]) n_magic_bad = 1'b1;
                end
                7'd4: begin
                    if (i_byte != i_cfg.expected_abi) n_abi_bad = 1'b1;
                end
                [7'd5:7'd8]: begin
                    case (len_sel)
                        2'd0:    n_len[7:0]  = r_len[7:0]  | i_byte;
                        2'd1:    n_len[15:8] = r_len[15:8] | i_byte;
                        default: n_len_hi    = r_len_hi | (i_byte != 8'd0);
                    endcase
                end
                [7'd9:7'd12]: begin
                    n_dcrc[{dcrc_sel, 3'b000} +: 8] = r_dcrc[{dcrc_sel, 3'b000} +: 8] | i_byte;
                end
                default: begin
                    // reserved header bytes are ignored
                end
            endcase
            if (r_hdr_idx < CRC_LEN) n_crc = crc_step;
            n_hdr_idx = r_hdr_idx + 7'd1;

            if (r_hdr_idx == HDR_LAST) begin
                if (n_magic_bad) begin
                    o_result.done_res = 1'b1;
                    o_result.verdict  = V_MAGIC;
                end else if (n_abi_bad) begin
                    o_result.done_res = 1'b1;
                    o_result.verdict  = V_ABI;
                end else if (n_len_hi || n_len == 16'd0 || n_len > i_cfg.body_limit) begin
                    o_result.done_res = 1'b1;
                    o_result.verdict  = V_LENGTH;
                end
                if (o_result.done_res) begin
                    rearm = 1'b1;
                end else begin
                    n_in_body  = 1'b1;
                    n_body_idx = 16'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && rearm)) begin
            r_hdr_idx   <= 7'd0;
            r_in_body   <= 1'b0;
            r_body_idx  <= 16'd0;
            r_crc       <= CRC_INIT;
            r_len       <= 16'd0;
            r_len_hi    <= 1'b0;
            r_dcrc      <= 32'd0;
            r_magic_bad <= 1'b0;
            r_abi_bad   <= 1'b0;
        end else if (i_take) begin
            r_hdr_idx   <= n_hdr_idx;
            r_in_body   <= n_in_body;
            r_body_idx  <= n_body_idx;
            r_crc       <= n_crc;
            r_len       <= n_len;
            r_len_hi    <= n_len_hi;
            r_dcrc      <= n_dcrc;
            r_magic_bad <= n_magic_bad;
            r_abi_bad   <= n_abi_bad;
        end
    end

endmodule

/* rtl/firmware_image_verify_load.sv */
// ----------------------------------------------------------------------------
// firmware_image_verify_load
// Byte-serial firmware image checker and loader with CRC-32 verification.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------
//  in       | i_in_valid / o_in_stall    | i_image_byte
//  out      | o_out_valid / i_out_stall  | o_store_*, o_done_res, o_verdict
//  cfg      | i_cfg_we                   | i_cfg_index, i_cfg_data
//
//  One item per cycle while o_in_stall is low: each byte's result is
//  registered and shown in the cycle after the byte is accepted.
//  Reset clears the image state and loads the register defaults.
//  While a result waits under i_out_stall, o_in_stall holds the input; a
//  result that is taken frees the slot for an item in the same cycle.
// ----------------------------------------------------------------------------
module firmware_image_verify_load
    import fvl_pkg::*;
#(
    parameter int HEADER_LENGTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_image_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_store_valid,
    output logic [15:0] o_store_addr,
    output logic [7:0]  o_store_data,
    output logic        o_done_res,
    output logic [2:0]  o_verdict,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_result result;
    t_result r_out;
    logic    r_out_valid;
    logic    take;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign take       = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_abi <= ABI_RESET;
            r_cfg.body_limit   <= LIMIT_RESET;
            r_cfg.load_base    <= BASE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ABI:   r_cfg.expected_abi <= i_cfg_data[7:0];
                CFG_LIMIT: r_cfg.body_limit   <= i_cfg_data;
                CFG_BASE:  r_cfg.load_base    <= i_cfg_data;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    fvl_parse #(
        .HEADER_LENGTH (HEADER_LENGTH)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_byte   (i_image_byte),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_store_valid = r_out.store_valid;
    assign o_store_addr  = r_out.store_addr;
    assign o_store_data  = r_out.store_data;
    assign o_done_res    = r_out.done_res;
    assign o_verdict     = r_out.verdict;

    // header faults never carry a store, body verdicts always do
    a_verdict_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |->
            (o_store_valid == (o_verdict == V_OK || o_verdict == V_CRC)))
        else $error("verdict and store disagree");

    a_verdict_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_done_res) |-> (o_verdict == V_OK))
        else $error("verdict set without done");

    a_store_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_store_valid) |-> (o_store_addr == 16'd0 && o_store_data == 8'd0))
        else $error("store fields set without store");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input held with no result waiting");

endmodule
